>>> hw/rtl/dds_pkg.sv
// Shared types and constants for the DAG dispatch scheduler.
// Holds channel payload structs, opcodes, status codes and the control interface.
// No dependencies.
`timescale 1ns / 1ps

package dds_pkg;

    localparam int MAX_NODES_DEF      = 64;
    localparam int DEVICE_CLASSES_DEF = 4;
    localparam int MAX_PER_DEVICE_DEF = 15;

    localparam int DEV_W  = 2;
    localparam int PRIO_W = 8;
    localparam int PEND_W = 7;
    localparam int CAP_W  = 4;
    localparam int NUM_CAP = 4;

    typedef enum logic [2:0] {
        OP_CLEAR    = 3'd0,
        OP_ADD_NODE = 3'd1,
        OP_ADD_DEP  = 3'd2,
        OP_DISPATCH = 3'd3,
        OP_COMPLETE = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NONE_FITS  = 3'd1,
        ST_STOPPED    = 3'd2,
        ST_ALL_DONE   = 3'd3,
        ST_TABLE_FULL = 3'd4,
        ST_BAD_REF    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_CLEAR,
        CMD_ADD,
        CMD_EDGE_RD1,
        CMD_EDGE_RD2,
        CMD_EDGE_WR,
        CMD_SCAN_START,
        CMD_SCAN,
        CMD_GRANT,
        CMD_CPL_RD,
        CMD_CPL_FREE,
        CMD_SWEEP
    } cmd_code_t;

    typedef struct packed {
        logic [2:0]        op;
        logic [1:0]        node_device;
        logic signed [7:0] node_priority;
        logic [5:0]        target_node;
        logic [5:0]        source_node;
        logic              success;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] granted_node;
        logic [1:0] granted_device;
        logic [5:0] running_count;
        logic [6:0] finished_count;
        logic [5:0] peak_running;
        logic [5:0] failed_node;
    } rsp_t;

    typedef struct packed {
        logic      latch;
        cmd_code_t code;
        logic      load_rsp;
        status_t   status;
    } cmd_t;

    typedef struct packed {
        logic add_full;
        logic add_bad_dev;
        logic edge_pre_bad;
        logic edge_bad;
        logic stopped;
        logic all_done;
        logic cpl_bad;
        logic success;
        logic walk_done;
        logic found;
    } flags_t;

endpackage

>>> hw/rtl/dag_dispatch_scheduler.sv
// Clear and add node finish in decode; add dependency reads the tables, then checks and writes.
// Dispatch walks the node table in the scan unit, one node table read per cycle.
// Completion on success frees the node, then sweeps its children (one pending-count read/write
// per cycle); on failure or a stopped schedule it ends after the free; rejects go to the result.
// One item is in work at a time; the next is taken while a result waits in the output register.
// Reset (rst_n, async, active low) empties the graph and sets every capacity register to 1.
`timescale 1ns / 1ps

module dag_dispatch_scheduler #(
    parameter int MAX_NODES      = dds_pkg::MAX_NODES_DEF,
    parameter int DEVICE_CLASSES = dds_pkg::DEVICE_CLASSES_DEF,
    parameter int MAX_PER_DEVICE = dds_pkg::MAX_PER_DEVICE_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  dds_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output dds_pkg::rsp_t rsp,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [3:0]    cfg_data
);

    dds_pkg::cmd_t   cmd;
    dds_pkg::flags_t flags;

    dds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_op    (req.op),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .flags     (flags)
    );

    dds_datapath #(
        .MAX_NODES      (MAX_NODES),
        .DEVICE_CLASSES (DEVICE_CLASSES),
        .MAX_PER_DEVICE (MAX_PER_DEVICE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .flags     (flags),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

>>> hw/rtl/dds_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module dds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/dds_ctrl.sv
// Controller state machine for the DAG dispatch scheduler.
// Sequences datapath commands per operation; depends on dds_pkg.
`timescale 1ns / 1ps

module dds_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  logic [2:0]      req_op,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output dds_pkg::cmd_t   cmd,
    input  dds_pkg::flags_t flags
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EDGE_RD,
        S_EDGE_CHK,
        S_SCAN,
        S_CPL,
        S_SWEEP,
        S_RESULT
    } state_t;

    state_t           state_reg, state_next;
    logic [2:0]       op_reg, op_next;
    dds_pkg::status_t status_reg, status_next;
    logic             rsp_valid_reg, rsp_valid_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd.latch      = 1'b0;
        cmd.code       = dds_pkg::CMD_IDLE;
        cmd.load_rsp   = 1'b0;
        cmd.status     = status_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    op_next    = req_op;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                status_next = dds_pkg::ST_OK;
                state_next  = S_RESULT;
                unique case (op_reg)
                    dds_pkg::OP_CLEAR:
                    begin
                        cmd.code = dds_pkg::CMD_CLEAR;
                    end
                    dds_pkg::OP_ADD_NODE:
                    begin
                        if (flags.add_full)
                        begin
                            status_next = dds_pkg::ST_TABLE_FULL;
                        end
                        else if (flags.add_bad_dev)
                        begin
                            status_next = dds_pkg::ST_BAD_REF;
                        end
                        else
                        begin
                            cmd.code = dds_pkg::CMD_ADD;
                        end
                    end
                    dds_pkg::OP_ADD_DEP:
                    begin
                        if (flags.edge_pre_bad)
                        begin
                            status_next = dds_pkg::ST_BAD_REF;
                        end
                        else
                        begin
                            cmd.code   = dds_pkg::CMD_EDGE_RD1;
                            state_next = S_EDGE_RD;
                        end
                    end
                    dds_pkg::OP_DISPATCH:
                    begin
                        if (flags.stopped)
                        begin
                            status_next = dds_pkg::ST_STOPPED;
                        end
                        else if (flags.all_done)
                        begin
                            status_next = dds_pkg::ST_ALL_DONE;
                        end
                        else
                        begin
                            cmd.code   = dds_pkg::CMD_SCAN_START;
                            state_next = S_SCAN;
                        end
                    end
                    dds_pkg::OP_COMPLETE:
                    begin
                        if (flags.cpl_bad)
                        begin
                            status_next = dds_pkg::ST_BAD_REF;
                        end
                        else
                        begin
                            cmd.code   = dds_pkg::CMD_CPL_RD;
                            state_next = S_CPL;
                        end
                    end
                    default:
                    begin
                        status_next = dds_pkg::ST_BAD_REF;
                    end
                endcase
            end
            S_EDGE_RD:
            begin
                cmd.code   = dds_pkg::CMD_EDGE_RD2;
                state_next = S_EDGE_CHK;
            end
            S_EDGE_CHK:
            begin
                state_next = S_RESULT;
                if (flags.edge_bad)
                begin
                    status_next = dds_pkg::ST_BAD_REF;
                end
                else
                begin
                    cmd.code = dds_pkg::CMD_EDGE_WR;
                end
            end
            S_SCAN:
            begin
                if (flags.walk_done)
                begin
                    state_next = S_RESULT;
                    if (flags.found)
                    begin
                        cmd.code = dds_pkg::CMD_GRANT;
                    end
                    else
                    begin
                        status_next = dds_pkg::ST_NONE_FITS;
                    end
                end
                else
                begin
                    cmd.code = dds_pkg::CMD_SCAN;
                end
            end
            S_CPL:
            begin
                cmd.code = dds_pkg::CMD_CPL_FREE;
                if (flags.stopped || !flags.success)
                begin
                    status_next = dds_pkg::ST_STOPPED;
                    state_next  = S_RESULT;
                end
                else
                begin
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (flags.walk_done)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.code = dds_pkg::CMD_SWEEP;
                end
            end
            S_RESULT:
            begin
                // hold until the previous result transfer has gone
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load_rsp   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            status_reg    <= dds_pkg::ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

>>> hw/rtl/dds_datapath.sv
// Datapath of the DAG dispatch scheduler: node tables, masks, counters and scan unit.
// Depends on dds_pkg and dds_ram.
`timescale 1ns / 1ps

module dds_datapath #(
    parameter int MAX_NODES      = dds_pkg::MAX_NODES_DEF,
    parameter int DEVICE_CLASSES = dds_pkg::DEVICE_CLASSES_DEF,
    parameter int MAX_PER_DEVICE = dds_pkg::MAX_PER_DEVICE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  dds_pkg::req_t   req,
    input  dds_pkg::cmd_t   cmd,
    output dds_pkg::flags_t flags,
    output dds_pkg::rsp_t   rsp,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [3:0]      cfg_data
);

    localparam int TABLE   = (MAX_NODES < 64) ? MAX_NODES : 64;
    localparam int IDW     = $clog2(TABLE);
    localparam int CW      = $clog2(TABLE + 1);
    localparam int CAP_LIM = (MAX_PER_DEVICE < 15) ? MAX_PER_DEVICE : 15;
    localparam int NODE_W  = dds_pkg::DEV_W + dds_pkg::PRIO_W;
    localparam logic [dds_pkg::CAP_W-1:0] CAP_MAX = CAP_LIM[dds_pkg::CAP_W-1:0];

    dds_pkg::req_t item_reg;
    dds_pkg::rsp_t rsp_reg;

    logic [dds_pkg::CAP_W-1:0] cap_reg    [dds_pkg::NUM_CAP];
    logic [dds_pkg::CAP_W-1:0] active_reg [dds_pkg::NUM_CAP];

    logic [CW-1:0]  node_total_reg, running_total_reg, finished_reg, peak_reg;
    logic           stopped_reg;
    logic [IDW-1:0] failing_reg;
    logic [TABLE-1:0] ready_reg, running_reg, child_row_reg;
    logic [IDW-1:0] gnode_reg;
    logic [1:0]     gdev_reg;
    logic [dds_pkg::PEND_W-1:0] pend_t_reg;

    // shared walk unit: scan over nodes for dispatch, sweep over children on completion
    logic [CW-1:0]  rd_idx_reg;
    logic           pipe_vld_reg;
    logic [IDW-1:0] pipe_idx_reg;
    logic           found_reg;
    logic [IDW-1:0] best_reg;
    logic signed [7:0] best_prio_reg;
    logic [1:0]     best_dev_reg;

    logic [IDW-1:0] tgt_idx, src_idx, id_idx, rd_idx;
    logic [TABLE-1:0] tgt_bit;
    logic           tgt_in, src_in;

    logic              node_we, child_we, pend_we;
    logic [IDW-1:0]    node_raddr, child_raddr, pend_raddr, child_waddr, pend_waddr;
    logic [NODE_W-1:0] node_wdata, node_rdata;
    logic [TABLE-1:0]  child_wdata, child_rdata;
    logic [dds_pkg::PEND_W-1:0] pend_wdata, pend_rdata;

    logic [1:0]        scan_dev;
    logic signed [7:0] scan_prio;
    logic [dds_pkg::CAP_W-1:0] eff_cap;
    logic              fits, better, src_done, sweep_hit;
    logic [CW-1:0]     running_inc;

    assign tgt_idx = IDW'(item_reg.target_node);
    assign src_idx = IDW'(item_reg.source_node);
    assign id_idx  = IDW'(node_total_reg);
    assign rd_idx  = rd_idx_reg[IDW-1:0];
    assign tgt_bit = {{(TABLE-1){1'b0}}, 1'b1} << tgt_idx;
    assign tgt_in  = {1'b0, item_reg.target_node} < 7'(node_total_reg);
    assign src_in  = {1'b0, item_reg.source_node} < 7'(node_total_reg);

    assign scan_dev  = node_rdata[NODE_W-1:dds_pkg::PRIO_W];
    assign scan_prio = node_rdata[dds_pkg::PRIO_W-1:0];
    assign eff_cap   = (cap_reg[scan_dev] < CAP_MAX) ? cap_reg[scan_dev] : CAP_MAX;
    assign fits      = ready_reg[pipe_idx_reg] && (active_reg[scan_dev] < eff_cap);
    assign better    = pipe_vld_reg && fits && (!found_reg || scan_prio > best_prio_reg);
    assign src_done  = !ready_reg[src_idx] && !running_reg[src_idx] && (pend_rdata == '0);
    assign sweep_hit = pipe_vld_reg && child_row_reg[pipe_idx_reg] && (pend_rdata != '0);
    assign running_inc = CW'(running_total_reg + 1'b1);

    assign flags.add_full     = int'(node_total_reg) >= TABLE;
    assign flags.add_bad_dev  = int'(item_reg.node_device) >= DEVICE_CLASSES;
    assign flags.edge_pre_bad = !tgt_in || !src_in
                                || (item_reg.target_node == item_reg.source_node)
                                || running_reg[tgt_idx];
    assign flags.edge_bad     = child_row_reg[tgt_idx]
                                || (!ready_reg[tgt_idx] && !running_reg[tgt_idx]
                                    && (pend_t_reg == '0));
    assign flags.stopped      = stopped_reg;
    assign flags.all_done     = (finished_reg == node_total_reg);
    assign flags.cpl_bad      = !tgt_in || !running_reg[tgt_idx];
    assign flags.success      = item_reg.success;
    assign flags.walk_done    = (rd_idx_reg == node_total_reg) && !pipe_vld_reg;
    assign flags.found        = found_reg;

    assign rsp = rsp_reg;

    always_comb
    begin
        node_we     = 1'b0;
        child_we    = 1'b0;
        pend_we     = 1'b0;
        node_raddr  = tgt_idx;
        child_raddr = tgt_idx;
        pend_raddr  = tgt_idx;
        child_waddr = id_idx;
        pend_waddr  = id_idx;
        node_wdata  = {item_reg.node_device, item_reg.node_priority};
        child_wdata = '0;
        pend_wdata  = '0;
        case (cmd.code)
            dds_pkg::CMD_ADD:
            begin
                node_we  = 1'b1;
                child_we = 1'b1;
                pend_we  = 1'b1;
            end
            dds_pkg::CMD_EDGE_RD1:
            begin
                child_raddr = src_idx;
            end
            dds_pkg::CMD_EDGE_RD2:
            begin
                pend_raddr = src_idx;
            end
            dds_pkg::CMD_EDGE_WR:
            begin
                // a source already done adds no pending dependency
                if (!src_done)
                begin
                    child_we    = 1'b1;
                    child_waddr = src_idx;
                    child_wdata = child_row_reg | tgt_bit;
                    pend_we     = 1'b1;
                    pend_waddr  = tgt_idx;
                    pend_wdata  = pend_t_reg + 1'b1;
                end
            end
            dds_pkg::CMD_SCAN:
            begin
                node_raddr = rd_idx;
            end
            dds_pkg::CMD_SWEEP:
            begin
                pend_raddr = rd_idx;
                if (sweep_hit)
                begin
                    pend_we    = 1'b1;
                    pend_waddr = pipe_idx_reg;
                    pend_wdata = pend_rdata - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    dds_ram #(.WIDTH(NODE_W), .DEPTH(TABLE)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (id_idx),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    dds_ram #(.WIDTH(TABLE), .DEPTH(TABLE)) u_child_ram (
        .clk   (clk),
        .we    (child_we),
        .waddr (child_waddr),
        .wdata (child_wdata),
        .raddr (child_raddr),
        .rdata (child_rdata)
    );

    dds_ram #(.WIDTH(dds_pkg::PEND_W), .DEPTH(TABLE)) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (pend_waddr),
        .wdata (pend_wdata),
        .raddr (pend_raddr),
        .rdata (pend_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg          <= '0;
            rsp_reg           <= '0;
            for (int i = 0; i < dds_pkg::NUM_CAP; i++)
            begin
                cap_reg[i]    <= dds_pkg::CAP_W'(1);
                active_reg[i] <= '0;
            end
            node_total_reg    <= '0;
            running_total_reg <= '0;
            finished_reg      <= '0;
            peak_reg          <= '0;
            stopped_reg       <= 1'b0;
            failing_reg       <= '0;
            ready_reg         <= '0;
            running_reg       <= '0;
            child_row_reg     <= '0;
            gnode_reg         <= '0;
            gdev_reg          <= '0;
            pend_t_reg        <= '0;
            rd_idx_reg        <= '0;
            pipe_vld_reg      <= 1'b0;
            pipe_idx_reg      <= '0;
            found_reg         <= 1'b0;
            best_reg          <= '0;
            best_prio_reg     <= '0;
            best_dev_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg[cfg_index] <= cfg_data;
            end

            if (cmd.latch)
            begin
                item_reg  <= req;
                gnode_reg <= '0;
                gdev_reg  <= '0;
            end

            // advance the shared walk pipeline
            if (cmd.code == dds_pkg::CMD_SCAN || cmd.code == dds_pkg::CMD_SWEEP)
            begin
                if (rd_idx_reg != node_total_reg)
                begin
                    pipe_vld_reg <= 1'b1;
                    pipe_idx_reg <= rd_idx;
                    rd_idx_reg   <= rd_idx_reg + 1'b1;
                end
                else
                begin
                    pipe_vld_reg <= 1'b0;
                end
            end

            case (cmd.code)
                dds_pkg::CMD_CLEAR:
                begin
                    for (int i = 0; i < dds_pkg::NUM_CAP; i++)
                    begin
                        active_reg[i] <= '0;
                    end
                    node_total_reg    <= '0;
                    running_total_reg <= '0;
                    finished_reg      <= '0;
                    peak_reg          <= '0;
                    stopped_reg       <= 1'b0;
                    failing_reg       <= '0;
                    ready_reg         <= '0;
                    running_reg       <= '0;
                end
                dds_pkg::CMD_ADD:
                begin
                    ready_reg[id_idx] <= 1'b1;
                    node_total_reg    <= node_total_reg + 1'b1;
                    gnode_reg         <= id_idx;
                    gdev_reg          <= item_reg.node_device;
                end
                dds_pkg::CMD_EDGE_RD2:
                begin
                    child_row_reg <= child_rdata;
                    pend_t_reg    <= pend_rdata;
                end
                dds_pkg::CMD_EDGE_WR:
                begin
                    if (!src_done)
                    begin
                        ready_reg[tgt_idx] <= 1'b0;
                    end
                end
                dds_pkg::CMD_SCAN_START:
                begin
                    rd_idx_reg   <= '0;
                    pipe_vld_reg <= 1'b0;
                    found_reg    <= 1'b0;
                end
                dds_pkg::CMD_SCAN:
                begin
                    if (better)
                    begin
                        found_reg     <= 1'b1;
                        best_reg      <= pipe_idx_reg;
                        best_prio_reg <= scan_prio;
                        best_dev_reg  <= scan_dev;
                    end
                end
                dds_pkg::CMD_GRANT:
                begin
                    ready_reg[best_reg]        <= 1'b0;
                    running_reg[best_reg]      <= 1'b1;
                    active_reg[best_dev_reg]   <= active_reg[best_dev_reg] + 1'b1;
                    running_total_reg          <= running_inc;
                    if (running_inc > peak_reg)
                    begin
                        peak_reg <= running_inc;
                    end
                    gnode_reg <= best_reg;
                    gdev_reg  <= best_dev_reg;
                end
                dds_pkg::CMD_CPL_FREE:
                begin
                    running_reg[tgt_idx] <= 1'b0;
                    if (active_reg[scan_dev] != '0)
                    begin
                        active_reg[scan_dev] <= active_reg[scan_dev] - 1'b1;
                    end
                    if (running_total_reg != '0)
                    begin
                        running_total_reg <= running_total_reg - 1'b1;
                    end
                    if (!stopped_reg)
                    begin
                        if (!item_reg.success)
                        begin
                            stopped_reg <= 1'b1;
                            failing_reg <= tgt_idx;
                        end
                        else
                        begin
                            finished_reg  <= finished_reg + 1'b1;
                            child_row_reg <= child_rdata;
                            rd_idx_reg    <= '0;
                            pipe_vld_reg  <= 1'b0;
                        end
                    end
                end
                dds_pkg::CMD_SWEEP:
                begin
                    // last dependency gone: child becomes ready
                    if (sweep_hit && pend_rdata == dds_pkg::PEND_W'(1))
                    begin
                        ready_reg[pipe_idx_reg] <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            if (cmd.load_rsp)
            begin
                rsp_reg.status         <= cmd.status;
                rsp_reg.granted_node   <= 6'(gnode_reg);
                rsp_reg.granted_device <= gdev_reg;
                rsp_reg.running_count  <= 6'(running_total_reg);
                rsp_reg.finished_count <= 7'(finished_reg);
                rsp_reg.peak_running   <= 6'(peak_reg);
                rsp_reg.failed_node    <= 6'(failing_reg);
            end
        end
    end

`ifndef SYNTHESIS
    a_running_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(running_reg) == int'(running_total_reg))
        else $error("running count does not match running mask");

    a_ready_running_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (ready_reg & running_reg) == '0)
        else $error("node both ready and running");

    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= running_total_reg)
        else $error("peak below running count");

    a_finished_bound: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg <= node_total_reg)
        else $error("more finished nodes than added");
`endif

endmodule
